FILE: src/sorted_list_priority_queue_top_assert.svh
// Assertion macros shared by the priority queue modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SORTED_LIST_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_LIST_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define SLPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SLPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SLPQ_ASSERT(label, prop, msg)

`define SLPQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: src/slpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               value_valid;
    logic               insert_refused;
    logic [4:0]         stored_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

FILE: src/slpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_priority_queue_top_assert.svh"

module slpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output slpq_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.exec  = (state_r == ST_EXEC);

  `SLPQ_ASSERT(a_accept_to_exec, (state_r == ST_IDLE && start) |=> (state_r == ST_EXEC), "accepted word did not start execution")
  `SLPQ_ASSERT(a_exec_to_done, (state_r == ST_EXEC) |=> (state_r == ST_DONE && out_valid), "execution not followed by a result strobe")
  `SLPQ_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe lasted more than one cycle")
  `SLPQ_ASSERT_ALWAYS(a_strobe_while_busy, out_valid |-> busy, "result strobe while not busy")

endmodule

`default_nettype wire

FILE: src/slpq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_priority_queue_top_assert.svh"

module slpq_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire slpq_pkg::cmd_t       cmd,
  input  wire slpq_pkg::in_word_t   in_word,
  output slpq_pkg::out_word_t       out_word
);

  logic                             func_r;
  logic signed [31:0]               value_r;
  logic signed [31:0]               store_r   [slpq_pkg::CAPACITY];
  logic signed [31:0]               store_nxt [slpq_pkg::CAPACITY];
  logic [slpq_pkg::CNT_W-1:0]       count_r;
  logic [slpq_pkg::CNT_W-1:0]       count_nxt;
  logic [slpq_pkg::CAPACITY-1:0]    gt;
  logic                             full;
  slpq_pkg::out_word_t              res_r;
  slpq_pkg::out_word_t              res_nxt;

  assign full = (count_r == slpq_pkg::CNT_W'(slpq_pkg::CAPACITY));

  // Every occupied entry compares against the new value at once; since the
  // store is sorted, the set of entries smaller than the value is a prefix.
  always_comb begin
    for (int i = 0; i < slpq_pkg::CAPACITY; i++) begin
      gt[i] = (slpq_pkg::CNT_W'(i) < count_r) && (value_r > store_r[i]);
    end
  end

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    res_nxt   = '0;
    if (func_r == slpq_pkg::FUNC_INSERT) begin
      if (full) begin
        res_nxt.insert_refused = 1'b1;
      end else begin
        store_nxt[0] = gt[0] ? store_r[0] : value_r;
        for (int i = 1; i < slpq_pkg::CAPACITY; i++) begin
          if (gt[i]) begin
            store_nxt[i] = store_r[i];
          end else if (gt[i-1]) begin
            store_nxt[i] = value_r;
          end else begin
            store_nxt[i] = store_r[i-1];
          end
        end
        count_nxt = count_r + slpq_pkg::CNT_W'(1);
      end
    end else begin
      if (count_r != '0) begin
        res_nxt.value_out   = store_r[0];
        res_nxt.value_valid = 1'b1;
        for (int i = 0; i < slpq_pkg::CAPACITY - 1; i++) begin
          store_nxt[i] = store_r[i+1];
        end
        count_nxt = count_r - slpq_pkg::CNT_W'(1);
      end
    end
    res_nxt.stored_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_word.func;
      value_r <= in_word.value_in;
    end
    if (cmd.exec) begin
      store_r <= store_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_word = res_r;

  `SLPQ_ASSERT(a_count_bound, count_r <= slpq_pkg::CNT_W'(slpq_pkg::CAPACITY), "entry count above capacity")
  `SLPQ_ASSERT(a_full_refuses, (cmd.exec && func_r == slpq_pkg::FUNC_INSERT && full) |=> (res_r.insert_refused && $stable(count_r)), "insert into full store not refused")
  `SLPQ_ASSERT(a_remove_empty, (cmd.exec && func_r == slpq_pkg::FUNC_REMOVE && count_r == '0) |=> (!res_r.value_valid && res_r.value_out == '0), "remove from empty store returned a value")

endmodule

`default_nettype wire

FILE: src/sorted_list_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue holding up to CAPACITY signed 32-bit values in
// ascending order. An input word is taken at a rising edge where start is
// high and busy is low. in_word.func selects insert (the value goes behind
// all stored values smaller than it, ahead of equal ones) or remove (the
// smallest value leaves). Every input word yields exactly one result word.
// The result word appears on out_word for one cycle, marked by out_valid,
// in the present state that follows the execute state. It carries the
// removed value (zero if none), a valid flag, a refused flag for an insert
// into a full store, and the count after the operation. busy stays high
// through the execute and present states, so no new word is taken until the
// result has been shown; the controller steps through load, execute and
// present, and the whole store compares and shifts in the execute state.
// The receiver cannot hold results off; each strobe must be taken when it
// appears.
// Synchronous reset empties the store at once; stored entries are not
// cleared, since only entries below the count are ever read.
module sorted_list_priority_queue_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire slpq_pkg::in_word_t   in_word,
  output logic                      out_valid,
  output slpq_pkg::out_word_t       out_word
);

  slpq_pkg::cmd_t cmd;

  slpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  slpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
